[rtl/core/nla_pkg.sv]
// Shared types and constants for the nearest-landmark association block.
`default_nettype none

package nla_pkg;

  // Default sizes
  localparam int unsigned MAX_LANDMARKS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF    = 24;

  // Fixed field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned ENTRY_W = 6;
  localparam int unsigned COUNT_W = 7;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } nla_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;   // write one table entry from the input item
    logic obs_ld;  // latch observation, clear best-match state
    logic rd_en;   // read one table entry into the compare pipeline
  } nla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_idle;  // no entry in flight in the compare pipeline
  } nla_stat_t;

endpackage

`default_nettype wire

[rtl/core/nla_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module nla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/nla_ctrl.sv]
// Controller: count register, item handshake, table scan sequencing.
`default_nettype none

module nla_ctrl import nla_pkg::*; #(
  parameter int unsigned MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  localparam int unsigned IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [ENTRY_W-1:0] entry_index_i,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_data_i,
  input  wire nla_stat_t          stat_i,
  output nla_cmd_t                cmd_o,
  output logic [IDX_W-1:0]        waddr_o,
  output logic [IDX_W-1:0]        raddr_o,
  output logic                    done_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LANDMARKS + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned EXT_W = ((IDX_W > ENTRY_W) ? IDX_W : ENTRY_W) + 1;

  nla_state_e         state_q, state_d;
  logic [COUNT_W-1:0] count_q;
  logic [CNT_W-1:0]   num_q, num_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;

  logic             accept;
  logic [CMP_W-1:0] count_ext, max_ext, num_sel;
  logic [EXT_W-1:0] idx_ext;
  logic             idx_ok;

  // Entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Clamp scan length to table depth
  assign count_ext = CMP_W'(count_q);
  assign max_ext   = CMP_W'(MAX_LANDMARKS);
  assign num_sel   = (count_ext > max_ext) ? max_ext : count_ext;

  // Load slot range check
  assign idx_ext = EXT_W'(entry_index_i);
  assign idx_ok  = idx_ext < EXT_W'(MAX_LANDMARKS);
  assign waddr_o = idx_ext[IDX_W-1:0];
  assign raddr_o = rd_cnt_q[IDX_W-1:0];

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign done_o = (state_q == ST_REPORT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      num_q    <= '0;
      rd_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      num_q    <= num_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    num_d        = num_q;
    rd_cnt_d     = rd_cnt_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            cmd_o.wr_en = idx_ok;
          end else begin
            cmd_o.obs_ld = 1'b1;
            num_d        = num_sel[CNT_W-1:0];
            rd_cnt_d     = '0;
            state_d      = (num_sel == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        rd_cnt_d    = rd_cnt_q + CNT_W'(1);
        if (rd_cnt_d == num_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.pipe_idle) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/nla_dpath.sv]
// Datapath: landmark table, distance pipeline and best-match registers.
`default_nettype none

module nla_dpath import nla_pkg::*; #(
  parameter int unsigned MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
  localparam int unsigned IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire nla_cmd_t                     cmd_i,
  input  wire logic [IDX_W-1:0]             waddr_i,
  input  wire logic [IDX_W-1:0]             raddr_i,
  input  wire logic [ID_W-1:0]              entry_id_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  output nla_stat_t                         stat_o,
  output logic                              found_o,
  output logic [ID_W-1:0]                   nearest_id_o,
  output logic signed [COORD_BITS:0]        offset_x_o,
  output logic signed [COORD_BITS:0]        offset_y_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned OW    = CB + 1;        // offset width
  localparam int unsigned PW    = 2 * OW;        // square width
  localparam int unsigned DW    = PW + 1;        // distance width
  localparam int unsigned ENT_W = ID_W + 2 * CB;

  // Observation latched for the whole scan
  logic [CB-1:0] obs_x_q, obs_y_q;

  // Table read data
  logic [ENT_W-1:0] rdata;
  logic [ID_W-1:0]  lm_id;
  logic [CB-1:0]    lm_x, lm_y;

  // Pipeline stages
  logic            vld1_q, vld2_q, vld3_q;
  logic [OW-1:0]   dx2_q, dy2_q, ax2_q, ay2_q;
  logic [ID_W-1:0] id2_q, id3_q;
  logic [OW-1:0]   dx3_q, dy3_q;
  logic [PW-1:0]   sqx3_q, sqy3_q;
  logic [OW-1:0]   dx_d, dy_d, ax_d, ay_d;
  logic [PW-1:0]   sqx_d, sqy_d;
  logic [DW-1:0]   dist_sum;
  logic            take;

  // Best match so far
  logic            have_q;
  logic [DW-1:0]   best_dist_q;
  logic [ID_W-1:0] best_id_q;
  logic [OW-1:0]   best_dx_q, best_dy_q;

  nla_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LANDMARKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr_i),
    .wdata_i ({entry_id_i, coord_x_i, coord_y_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  assign {lm_id, lm_x, lm_y} = rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.obs_ld) begin
      obs_x_q <= coord_x_i;
      obs_y_q <= coord_y_i;
    end
  end

  // Valid bits along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= cmd_i.rd_en;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Stage 2: offsets and magnitudes
  assign dx_d = {obs_x_q[CB-1], obs_x_q} - {lm_x[CB-1], lm_x};
  assign dy_d = {obs_y_q[CB-1], obs_y_q} - {lm_y[CB-1], lm_y};
  assign ax_d = dx_d[OW-1] ? (~dx_d + OW'(1)) : dx_d;
  assign ay_d = dy_d[OW-1] ? (~dy_d + OW'(1)) : dy_d;

  always_ff @(posedge clk_i) begin
    dx2_q <= dx_d;
    dy2_q <= dy_d;
    ax2_q <= ax_d;
    ay2_q <= ay_d;
    id2_q <= lm_id;
  end

  // Stage 3: squares
  assign sqx_d = ax2_q * ax2_q;
  assign sqy_d = ay2_q * ay2_q;

  always_ff @(posedge clk_i) begin
    sqx3_q <= sqx_d;
    sqy3_q <= sqy_d;
    dx3_q  <= dx2_q;
    dy3_q  <= dy2_q;
    id3_q  <= id2_q;
  end

  // Stage 4: distance and strict-less compare, earlier entry keeps a tie
  assign dist_sum = {1'b0, sqx3_q} + {1'b0, sqy3_q};
  assign take     = vld3_q && (!have_q || (dist_sum < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.obs_ld) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.obs_ld) begin
      best_dist_q <= '0;
      best_id_q   <= '0;
      best_dx_q   <= '0;
      best_dy_q   <= '0;
    end else if (take) begin
      best_dist_q <= dist_sum;
      best_id_q   <= id3_q;
      best_dx_q   <= dx3_q;
      best_dy_q   <= dy3_q;
    end
  end

  assign stat_o.pipe_idle = !(vld1_q || vld2_q || vld3_q);

  assign found_o      = have_q;
  assign nearest_id_o = best_id_q;
  assign offset_x_o   = best_dx_q;
  assign offset_y_o   = best_dy_q;

endmodule

`default_nettype wire

[rtl/core/nearest_landmark_association.sv]
// Top level of the nearest-landmark association block.
//
// Usage: an item is taken when start is high and busy is low. With op_i at
// load, the item writes entry_id_i, coord_x_i and coord_y_i into table slot
// entry_index_i (slots at or above MAX_LANDMARKS are dropped); a load keeps
// busy low and gives no result. With op_i at query, the block scans the
// first landmark_count entries (clamped to MAX_LANDMARKS), one table read
// per cycle, through a four-stage read/subtract/square/compare pipeline, and
// returns the closest entry's id and observation-minus-landmark offsets.
// busy stays high through the done_o cycle, so a query is through before the
// next item is taken; the next item can be taken in the cycle after done_o.
// An empty scan reads no table entries.
// done_o is high for exactly one cycle with the result fields valid; the
// receiver cannot stall. An empty scan answers found_o = 0 with zero fields.
// cfg_we_i/cfg_data_i write landmark_count; write it only while idle.
// Reset clears the count to 0 and returns to idle; table contents are
// undefined until loaded.
`default_nettype none

module nearest_landmark_association import nla_pkg::*; #(
  parameter int unsigned MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         op_i,
  input  wire logic [ENTRY_W-1:0]           entry_index_i,
  input  wire logic [ID_W-1:0]              entry_id_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [COUNT_W-1:0]           cfg_data_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [ID_W-1:0]                   nearest_id_o,
  output logic signed [COORD_BITS:0]        offset_x_o,
  output logic signed [COORD_BITS:0]        offset_y_o
);

  localparam int unsigned IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;

  nla_cmd_t         cmd;
  nla_stat_t        stat;
  logic [IDX_W-1:0] waddr, raddr;

  nla_ctrl #(
    .MAX_LANDMARKS (MAX_LANDMARKS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .waddr_o       (waddr),
    .raddr_o       (raddr),
    .done_o        (done_o)
  );

  nla_dpath #(
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .COORD_BITS    (COORD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .waddr_i      (waddr),
    .raddr_i      (raddr),
    .entry_id_i   (entry_id_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .stat_o       (stat),
    .found_o      (found_o),
    .nearest_id_o (nearest_id_o),
    .offset_x_o   (offset_x_o),
    .offset_y_o   (offset_y_o)
  );

endmodule

`default_nettype wire

[tb/sv/nearest_landmark_association_tb.sv]
// Self-checking testbench for the nearest-landmark association block.
module nearest_landmark_association_tb;
  import nla_pkg::*;

  localparam int unsigned COORD_W     = COORD_BITS_DEF;
  localparam int unsigned MAX_LM      = MAX_LANDMARKS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_SHOWN    = 10;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // How widely landmarks and observations are spread in a phase
  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_TIGHT,
    SPREAD_MID
  } spread_e;

  // One association answer
  typedef struct packed {
    logic                      found;
    logic [ID_W-1:0]           nearest_id;
    logic signed [COORD_W:0]   off_x;
    logic signed [COORD_W:0]   off_y;
  } match_t;

  // Landmark table mirror, nearest-match search and answer checking
  class assoc_scoreboard;
    logic signed [COORD_W-1:0] land_x  [MAX_LM];
    logic signed [COORD_W-1:0] land_y  [MAX_LM];
    logic [ID_W-1:0]           land_id [MAX_LM];
    logic [COUNT_W-1:0]        scan_count;
    match_t                    pending_matches[$];
    int unsigned               mismatches;
    int unsigned               results_seen;

    function new();
      foreach (land_x[i]) begin
        land_x[i]  = '0;
        land_y[i]  = '0;
        land_id[i] = '0;
      end
      scan_count   = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      scan_count = value;
    endfunction

    // Loads update the table; queries queue the nearest entry
    function void note_item(logic op, logic [ENTRY_W-1:0] slot, logic [ID_W-1:0] id,
                            logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
      match_t      m;
      int unsigned n;
      longint      dx, dy, sq_dist, best;
      bit          have;
      if (op == OP_LOAD) begin
        land_x[slot]  = cx;
        land_y[slot]  = cy;
        land_id[slot] = id;
      end else begin
        n    = (scan_count > MAX_LM) ? MAX_LM : scan_count;
        m    = '0;
        have = 1'b0;
        best = 0;
        for (int i = 0; i < int'(n); i++) begin
          dx      = longint'(cx) - longint'(land_x[i]);
          dy      = longint'(cy) - longint'(land_y[i]);
          sq_dist = dx * dx + dy * dy;
          // strict compare keeps the earlier entry on a tie
          if (!have || sq_dist < best) begin
            have         = 1'b1;
            best         = sq_dist;
            m.found      = 1'b1;
            m.nearest_id = land_id[i];
            m.off_x      = dx[COORD_W:0];
            m.off_y      = dy[COORD_W:0];
          end
        end
        pending_matches.push_back(m);
      end
    endfunction

    function void check_result(logic found, logic [ID_W-1:0] id,
                               logic signed [COORD_W:0] ox, logic signed [COORD_W:0] oy);
      match_t want;
      match_t got;
      got = {found, id, ox, oy};
      results_seen++;
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: found=%0b id=%0h dx=%0d dy=%0d",
                   got.found, got.nearest_id, got.off_x, got.off_y);
      end else begin
        want = pending_matches.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display({"mismatch: expected found=%0b id=%0h dx=%0d dy=%0d,",
                      " got found=%0b id=%0h dx=%0d dy=%0d"},
                     want.found, want.nearest_id, want.off_x, want.off_y,
                     got.found, got.nearest_id, got.off_x, got.off_y);
        end
      end
    endfunction
  endclass

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       start         = 1'b0;
  logic                       busy;
  logic                       op_i          = OP_LOAD;
  logic [ENTRY_W-1:0]         entry_index_i = '0;
  logic [ID_W-1:0]            entry_id_i    = '0;
  logic signed [COORD_W-1:0]  coord_x_i     = '0;
  logic signed [COORD_W-1:0]  coord_y_i     = '0;
  logic                       cfg_we_i      = 1'b0;
  logic [COUNT_W-1:0]         cfg_data_i    = '0;
  logic                       done_o;
  logic                       found_o;
  logic [ID_W-1:0]            nearest_id_o;
  logic signed [COORD_W:0]    offset_x_o;
  logic signed [COORD_W:0]    offset_y_o;

  assoc_scoreboard assoc_board = new();
  bit              slot_loaded [MAX_LM];
  int unsigned     loads_sent;
  int unsigned     queries_sent;
  int unsigned     count_writes;

  nearest_landmark_association i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_id_i    (entry_id_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .nearest_id_o  (nearest_id_o),
    .offset_x_o    (offset_x_o),
    .offset_y_o    (offset_y_o)
  );

  // Clock
  always #2 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      assoc_board.check_result(found_o, nearest_id_o, offset_x_o, offset_y_o);
  end

  // Watchdog on cycles with no accepted item and no result
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("nearest_landmark_association verification failed");
    $finish;
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(input logic op, input logic [ENTRY_W-1:0] slot,
                           input logic [ID_W-1:0] id,
                           input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy);
    op_i          <= op;
    entry_index_i <= slot;
    entry_id_i    <= id;
    coord_x_i     <= cx;
    coord_y_i     <= cy;
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    assoc_board.note_item(op, slot, id, cx, cy);
    if (op == OP_LOAD) begin
      slot_loaded[slot] = 1'b1;
      loads_sent++;
    end else begin
      queries_sent++;
    end
  endtask

  // Sender gap: mostly none or short, now and then long
  task automatic idle_gap(input bit steady);
    int unsigned pick;
    int unsigned len;
    len = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      len = 0;
      else if (pick < 90) len = $urandom_range(1, 3);
      else if (pick < 98) len = $urandom_range(4, 12);
      else                len = $urandom_range(20, 60);
    end
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // Stop sending until every answer is in, then let loads settle
  task automatic drain_and_settle();
    start <= 1'b0;
    while (assoc_board.pending_matches.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // data moves while the enable is low and must be ignored
    cfg_data_i <= COUNT_W'($urandom);
    assoc_board.set_count(value);
    count_writes++;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord(spread_e spread);
    case (spread)
      SPREAD_FULL: begin
        if ($urandom_range(0, 15) == 0)
          return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        return COORD_W'($urandom);
      end
      SPREAD_TIGHT: return COORD_W'($urandom_range(0, 16) - 8);
      default:      return COORD_W'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  // One random item; a query that would scan an unloaded slot becomes a load of it
  task automatic random_item(input spread_e spread);
    int unsigned               n;
    int unsigned               j;
    int                        hole;
    logic [ENTRY_W-1:0]        slot;
    logic signed [COORD_W-1:0] qx, qy;
    n    = (assoc_board.scan_count > MAX_LM) ? MAX_LM : assoc_board.scan_count;
    hole = -1;
    for (int i = int'(n) - 1; i >= 0; i--)
      if (!slot_loaded[i]) hole = i;
    if (hole >= 0 || $urandom_range(0, 99) < 40) begin
      if (hole >= 0)
        slot = ENTRY_W'(hole);
      else if (n == 0 || $urandom_range(0, 3) == 0)
        slot = ENTRY_W'($urandom_range(0, MAX_LM - 1));
      else
        slot = ENTRY_W'($urandom_range(0, n - 1));
      send_item(OP_LOAD, slot, ID_W'($urandom), rand_coord(spread), rand_coord(spread));
    end else begin
      if (n != 0 && $urandom_range(0, 1) == 1) begin
        // observation close to a stored landmark
        j  = $urandom_range(0, n - 1);
        qx = assoc_board.land_x[j] ^ COORD_W'(spread == SPREAD_FULL ?
                                              $urandom_range(0, 255) : $urandom_range(0, 3));
        qy = assoc_board.land_y[j] ^ COORD_W'(spread == SPREAD_FULL ?
                                              $urandom_range(0, 255) : $urandom_range(0, 3));
      end else begin
        qx = rand_coord(spread);
        qy = rand_coord(spread);
      end
      send_item(OP_QUERY, ENTRY_W'($urandom), ID_W'($urandom), qx, qy);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned        phase;
    int unsigned        phase_len;
    int unsigned        items_done;
    int unsigned        pick;
    logic [COUNT_W-1:0] cnt;
    spread_e            spread;
    bit                 steady;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table straight out of reset
    send_item(OP_QUERY, '0, '0, COORD_MIN, COORD_MAX);

    // corner landmarks, two on the same spot, one at the last slot
    send_item(OP_LOAD, 6'd0,  16'hFFFF, COORD_MAX, COORD_MIN);
    send_item(OP_LOAD, 6'd1,  16'h0000, COORD_MIN, COORD_MAX);
    send_item(OP_LOAD, 6'd2,  16'h1234, '0, '0);
    send_item(OP_LOAD, 6'd3,  16'h5678, '0, '0);
    send_item(OP_LOAD, 6'd4,  16'h0042, 24'sd2, '0);
    send_item(OP_LOAD, 6'd63, 16'hA5A5, -24'sd1, 24'sd1);
    drain_and_settle();

    // one entry: largest possible offsets, then an exact hit
    write_count(COUNT_W'(1));
    send_item(OP_QUERY, '0, '0, COORD_MIN, COORD_MAX);
    send_item(OP_QUERY, '0, '0, COORD_MAX, COORD_MIN);
    drain_and_settle();

    // five entries: identical spots, equal distances, later strictly closer, far corner tie
    write_count(COUNT_W'(5));
    send_item(OP_QUERY, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, '0, 24'sd1, '0);
    send_item(OP_QUERY, '0, '0, 24'sd2, 24'sd1);
    send_item(OP_QUERY, '0, '0, COORD_MIN, COORD_MAX);
    send_item(OP_QUERY, '0, '0, COORD_MAX, COORD_MAX);
    drain_and_settle();

    // random phases, each with its own table size and spread
    items_done = 0;
    phase      = 0;
    while (items_done < RANDOM_ITEMS) begin
      case (phase)
        0: cnt = '0;
        1: cnt = COUNT_W'(MAX_LM);
        2: cnt = '1;
        3: cnt = COUNT_W'(MAX_LM + 1);
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 50)      cnt = COUNT_W'($urandom_range(1, 8));
          else if (pick < 80) cnt = COUNT_W'($urandom_range(9, MAX_LM - 1));
          else if (pick < 92) cnt = COUNT_W'($urandom_range(MAX_LM, 127));
          else                cnt = '0;
        end
      endcase
      write_count(cnt);
      spread    = spread_e'($urandom_range(0, 2));
      steady    = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 100);
      repeat (phase_len) begin
        random_item(spread);
        items_done++;
        idle_gap(steady);
        if ($urandom_range(0, 49) == 0) drain_and_settle();
      end
      drain_and_settle();
      phase++;
    end

    start <= 1'b0;
    while (assoc_board.pending_matches.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("sent %0d loads and %0d queries across %0d table-size settings",
             loads_sent, queries_sent, count_writes);
    $display("checked %0d association results, %0d mismatches, %0d answers missing",
             assoc_board.results_seen, assoc_board.mismatches,
             assoc_board.pending_matches.size());
    if (assoc_board.mismatches == 0 && assoc_board.pending_matches.size() == 0)
      $display("nearest_landmark_association verification clean");
    else
      $display("nearest_landmark_association verification failed");
    $finish;
  end

endmodule
